### hw/rtl/sqe_pkg.sv
package sqe_pkg;

  // Running sum and divider dividend width.
  localparam int unsigned SUM_W = 64;

  // Quantile registers are unsigned Q1.16: one integer bit and 16 fraction bits.
  localparam int unsigned Q_W    = 17;
  localparam int unsigned Q_FRAC = 16;
  localparam logic [Q_W-1:0] QONE = 17'd65536;

  // Configuration register map.
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_Q  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_THR = 1'd1;

  localparam logic [Q_W-1:0] TARGET_Q_RST  = 17'd32768;
  localparam logic [Q_W-1:0] RANGE_THR_RST = 17'd45875;

  // Quotient bits retired by the divider in each cycle.
  localparam int unsigned DIV_BITS = 2;

endpackage

### hw/rtl/sqe_in_if.sv
interface sqe_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### hw/rtl/sqe_out_if.sv
interface sqe_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] estimate;
  logic signed [SAMPLE_WIDTH-1:0] step_size;

  modport source (output valid, output estimate, output step_size, input ready);
  modport sink   (input valid, input estimate, input step_size, output ready);
endinterface

### hw/rtl/sqe_div.sv
module sqe_div import sqe_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [COUNT_WIDTH-1:0]  divisor_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] quotient_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned ITER   = SUM_W / DIV_BITS;
  localparam int unsigned ITER_W = $clog2(ITER);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER - 1);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic              neg_q;
  logic [CW:0]       rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CW-1:0]     dsr_q;
  logic [SUM_W-1:0]  mag;

  // Work on magnitudes; the divisor is always positive, so the quotient
  // takes the dividend's sign and truncates toward zero.
  assign mag = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);

  always_comb begin
    logic [CW:0]      r;
    logic [SUM_W-1:0] qv;
    r  = rem_q;
    qv = quo_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      r  = {r[CW-1:0], qv[SUM_W-1]};
      qv = {qv[SUM_W-2:0], 1'b0};
      if (r >= {1'b0, dsr_q}) begin
        r     = r - {1'b0, dsr_q};
        qv[0] = 1'b1;
      end
    end
    rem_d = r;
    quo_d = qv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_LAST;
      end else if (busy_q) begin
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q - ITER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      quo_q <= mag;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### hw/rtl/streaming_quantile_estimator.sv
// Streaming quantile estimator.
// Samples arrive on smp_i (valid/ready, signed fixed point) and one result
// per sample leaves on res_o: the estimate after that sample and the step
// that was worked out for it. Two registers are written through the plain
// write port: index 0 is the target quantile and index 1 the threshold above
// which the step is the seen range over n-1 rather than twice the mean over
// n-1. Both are Q1.16 and values above one count as one.
// One sample is handled at a time. The first sample after reset goes straight
// to the result without the divider. Later samples run through the shared
// divider, which retires two quotient bits a cycle over a 64-bit dividend:
// one division in range mode and two divisions back to back in mean mode.
// smp_i.ready is high only while idle.
// The result sits in an output register, so a new sample is taken while the
// previous result still waits; if the receiver stalls, the following result
// holds the sequencer until that register is free.
// Reset clears the estimate, sum and counters, sets the largest seen value to
// minus one and the smallest to the most positive value, and reloads the
// register defaults. There is no clearing pass.
module streaming_quantile_estimator import sqe_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sqe_in_if.sink               smp_i,
  sqe_out_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [Q_W-1:0]       cfg_wdata_i
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;
  // The largest seen value must hold minus one even for narrow samples.
  localparam int unsigned MW = (SAMPLE_WIDTH > FRAC_BITS + 1) ? SAMPLE_WIDTH : FRAC_BITS + 1;
  localparam int unsigned PW = CW + Q_W;

  localparam logic signed [SW-1:0] SMAX    = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN    = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [MW-1:0] MAX_RST = $signed(MW'(0) - (MW'(1) << FRAC_BITS));
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_MID   = 3'd3;
  localparam logic [2:0] ST_DIV2  = 3'd4;
  localparam logic [2:0] ST_APPLY = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  function automatic logic signed [SW-1:0] sat_smp(input logic signed [SUM_W:0] v);
    logic signed [SW-1:0] r;
    if (v > (SUM_W+1)'(SMAX)) begin
      r = SMAX;
    end else if (v < (SUM_W+1)'(SMIN)) begin
      r = SMIN;
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] c);
    return (c == '1) ? c : c + CW'(1);
  endfunction

  logic [2:0]              state_q, state_d;
  logic [Q_W-1:0]          tq_q, thr_q;
  logic signed [SW-1:0]    est_q, est_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [MW-1:0]    max_q, max_d;
  logic signed [SW-1:0]    min_q, min_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           below_q, below_d;
  logic [CW-1:0]           above_q, above_d;
  logic                    mode_q, mode_d;
  logic                    le_q, le_d;
  logic [Q_W-1:0]          qsel_q, qsel_d;
  logic signed [SW-1:0]    step_q, step_d;
  logic [PW-1:0]           prod_q, prod_d;

  logic                    out_vld_q;
  logic signed [SW-1:0]    out_est_q, out_step_q;
  logic                    out_load;

  logic                    div_start;
  logic signed [SUM_W-1:0] div_dividend;
  logic [CW-1:0]           div_divisor;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_quot;

  logic signed [SW-1:0]    smp;
  logic [Q_W-1:0]          q_clamp, t_clamp;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [MW:0]      range_wide;
  logic [CW-1:0]           cnt_sel;
  logic [PW-1:0]           lhs;
  logic                    move;
  logic signed [SW:0]      est_wide;

  assign smp      = smp_i.sample;
  assign q_clamp  = (tq_q > QONE) ? QONE : tq_q;
  assign t_clamp  = (thr_q > QONE) ? QONE : thr_q;
  assign sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(smp);
  assign range_wide = (MW+1)'(max_q) - (MW+1)'(min_q);

  // Counter test against n*q (or n*(1-q)), with the count plus one scaled by one.
  assign cnt_sel  = le_q ? below_q : above_q;
  assign lhs      = {(CW+1)'(cnt_sel) + (CW+1)'(1), {Q_FRAC{1'b0}}};
  assign move     = lhs > prod_q;
  assign est_wide = le_q ? (SW+1)'(est_q) - (SW+1)'(step_q)
                         : (SW+1)'(est_q) + (SW+1)'(step_q);

  always_comb begin
    state_d      = state_q;
    est_d        = est_q;
    sum_d        = sum_q;
    max_d        = max_q;
    min_d        = min_q;
    cnt_d        = cnt_q;
    below_d      = below_q;
    above_d      = above_q;
    mode_d       = mode_q;
    le_d         = le_q;
    qsel_d       = qsel_q;
    step_d       = step_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    case (state_q)
      ST_IDLE: begin
        if (smp_i.valid) begin
          cnt_d = inc_sat(cnt_q);
          if (cnt_q == '0) begin
            est_d   = smp;
            step_d  = '0;
            state_d = ST_DONE;
          end else begin
            // A new minimum does not also update the maximum.
            if (smp < min_q) begin
              min_d = smp;
            end else if (MW'(smp) > max_q) begin
              max_d = MW'(smp);
            end
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
              sum_d = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
              sum_d = SUM_W'(sum_wide);
            end
            mode_d  = q_clamp > t_clamp;
            le_d    = smp <= est_q;
            qsel_d  = (smp <= est_q) ? q_clamp : QONE - q_clamp;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        prod_d    = PW'(cnt_q) * PW'(qsel_q);
        div_start = 1'b1;
        if (mode_q) begin
          div_dividend = SUM_W'(range_wide);
          div_divisor  = cnt_q - CW'(1);
        end else begin
          div_dividend = sum_q;
          div_divisor  = cnt_q;
        end
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_done) begin
          if (mode_q) begin
            step_d  = sat_smp((SUM_W+1)'(div_quot));
            state_d = ST_APPLY;
          end else begin
            state_d = ST_MID;
          end
        end
      end
      ST_MID: begin
        // Mean over n is now held in the divider; divide it by n-1.
        div_start    = 1'b1;
        div_dividend = div_quot;
        div_divisor  = cnt_q - CW'(1);
        state_d      = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_done) begin
          step_d  = sat_smp($signed({div_quot, 1'b0}));
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (move) begin
          if (est_wide[SW] != est_wide[SW-1]) begin
            est_d = est_wide[SW] ? SMIN : SMAX;
          end else begin
            est_d = SW'(est_wide);
          end
        end
        if (le_q == move) begin
          above_d = inc_sat(above_q);
        end else begin
          below_d = inc_sat(below_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tq_q    <= TARGET_Q_RST;
      thr_q   <= RANGE_THR_RST;
      est_q   <= '0;
      sum_q   <= '0;
      max_q   <= MAX_RST;
      min_q   <= SMAX;
      cnt_q   <= '0;
      below_q <= '0;
      above_q <= '0;
      mode_q  <= 1'b0;
      le_q    <= 1'b0;
      qsel_q  <= '0;
      step_q  <= '0;
      prod_q  <= '0;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      cnt_q   <= cnt_d;
      below_q <= below_d;
      above_q <= above_d;
      mode_q  <= mode_d;
      le_q    <= le_d;
      qsel_q  <= qsel_d;
      step_q  <= step_d;
      prod_q  <= prod_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET_Q:  tq_q  <= cfg_wdata_i;
          REG_RANGE_THR: thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_est_q  <= est_q;
      out_step_q <= step_q;
    end
  end

  sqe_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign smp_i.ready     = (state_q == ST_IDLE);
  assign res_o.valid     = out_vld_q;
  assign res_o.estimate  = out_est_q;
  assign res_o.step_size = out_step_q;

`ifndef SYNTH
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_i.valid && smp_i.ready |=> !smp_i.ready)
    else $error("sample accepted while the previous one is still in work");

  a_div_done_when_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
    else $error("divider finished outside a division wait state");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_divisor != '0)
    else $error("divider started with a zero divisor");

  a_result_handed_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> res_o.valid && state_q == ST_IDLE)
    else $error("finished item not moved to the output register");
`endif

endmodule

### tb/tb_streaming_quantile_estimator.sv
module tb_streaming_quantile_estimator;
  import sqe_pkg::*;

  localparam longint SMP_MAX = 64'sd2147483647;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint CNT_MAX = 64'sd4294967295;
  localparam longint QSCALE = 65536;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SEND_SIDE = 0;
  localparam int unsigned SINK_SIDE = 1;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic signed [31:0] step_size;
  } quantile_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [Q_W-1:0] cfg_wdata;

  sqe_in_if #(.SAMPLE_WIDTH(32)) smp_if ();
  sqe_out_if #(.SAMPLE_WIDTH(32)) res_if ();

  streaming_quantile_estimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  // Own copy of the estimator state and of the two quantile registers.
  longint tracked_estimate;
  longint tracked_sum;
  longint largest_sample;
  longint smallest_sample;
  longint samples_seen;
  longint below_hits;
  longint above_hits;
  logic [Q_W-1:0] target_q;
  logic [Q_W-1:0] range_thr;

  quantile_result_t expected_estimates[$];
  quantile_result_t oldest;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned samples_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  int unsigned calm_left[2];

  function automatic longint clip_sample(input longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  function automatic longint bump_count(input longint c);
    return (c >= CNT_MAX) ? CNT_MAX : c + 1;
  endfunction

  function automatic longint limit_q(input logic [Q_W-1:0] v);
    return (v > QONE) ? QSCALE : longint'(v);
  endfunction

  function automatic quantile_result_t track_quantile(input longint s);
    quantile_result_t r;
    longint n;
    longint q;
    longint t;
    longint step;
    step = 0;
    samples_seen = bump_count(samples_seen);
    if (samples_seen <= 1) begin
      tracked_estimate = s;
    end else begin
      n = samples_seen;
      q = limit_q(target_q);
      t = limit_q(range_thr);
      // A new minimum leaves the maximum alone.
      if (s < smallest_sample) begin
        smallest_sample = s;
      end else if (s > largest_sample) begin
        largest_sample = s;
      end
      if (s > 0 && tracked_sum > SUM_MAX - s) begin
        tracked_sum = SUM_MAX;
      end else if (s < 0 && tracked_sum < SUM_MIN - s) begin
        tracked_sum = SUM_MIN;
      end else begin
        tracked_sum = tracked_sum + s;
      end
      if (q > t) begin
        step = (largest_sample - smallest_sample) / (n - 1);
      end else begin
        step = ((tracked_sum / n) / (n - 1)) * 2;
      end
      step = clip_sample(step);
      if (s <= tracked_estimate) begin
        if ((below_hits + 1) * QSCALE > n * q) begin
          tracked_estimate = clip_sample(tracked_estimate - step);
          above_hits = bump_count(above_hits);
        end else begin
          below_hits = bump_count(below_hits);
        end
      end else begin
        if ((above_hits + 1) * QSCALE > n * QSCALE - n * q) begin
          tracked_estimate = clip_sample(tracked_estimate + step);
          below_hits = bump_count(below_hits);
        end else begin
          above_hits = bump_count(above_hits);
        end
      end
    end
    r.estimate = tracked_estimate[31:0];
    r.step_size = step[31:0];
    return r;
  endfunction

  // Mostly short random waits, with the odd stretch of back-to-back items.
  function automatic int unsigned draw_gap(input int unsigned side);
    if (calm_left[side] > 0) begin
      calm_left[side] = calm_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic signed [31:0] draw_sample(input longint centre);
    int unsigned pick;
    longint span;
    longint v;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      v = longint'($signed($urandom));
    end else if (pick < 5) begin
      case ($urandom_range(0, 4))
        0: v = SMP_MAX;
        1: v = SMP_MIN;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end else if (pick < 13) begin
      // Close to the current estimate, so that both directions keep firing.
      span = longint'(1) << $urandom_range(2, 22);
      v = tracked_estimate + longint'($urandom_range(0, 32'(2 * span))) - span;
    end else begin
      span = longint'(1) << $urandom_range(8, 20);
      v = centre + longint'($urandom_range(0, 32'(span)))
        + longint'($urandom_range(0, 32'(span))) - span;
    end
    v = clip_sample(v);
    return v[31:0];
  endfunction

  task automatic send_sample(input logic signed [31:0] value);
    int unsigned gap;
    gap = draw_gap(SEND_SIDE);
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= value;
    do @(posedge clk_i); while (!smp_if.ready);
    expected_estimates.push_back(track_quantile(longint'(value)));
    samples_sent++;
  endtask

  task automatic drain_results();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_estimates.size() != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_TARGET_Q) begin
      target_q = value;
    end else begin
      range_thr = value;
    end
  endtask

  task automatic set_quantile(input logic [Q_W-1:0] quantile, input logic [Q_W-1:0] threshold);
    drain_results();
    write_reg(REG_TARGET_Q, quantile);
    write_reg(REG_RANGE_THR, threshold);
    settings_used++;
  endtask

  // Mean mode with q at one: the first sample is taken as it is, and a large
  // second sample drives the estimate past the top of the range.
  task automatic test_first_sample_and_clipping();
    set_quantile(QONE, 17'h1FFFF);
    send_sample(32'(SMP_MAX - 99));
    send_sample(32'(SMP_MAX));
    send_sample(32'(SMP_MIN));
    send_sample(32'sd0);
  endtask

  task automatic test_field_extremes();
    set_quantile(TARGET_Q_RST, RANGE_THR_RST);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    send_sample(-32'sd65536);
    send_sample(32'sd65536);
    send_sample(32'(SMP_MIN));
    send_sample(32'(SMP_MAX));
  endtask

  task automatic test_register_extremes();
    // Target above one counts as one, so range mode with a zero threshold.
    set_quantile(17'h1FFFF, 17'd0);
    send_sample(32'(SMP_MIN));
    send_sample(32'(SMP_MAX));
    send_sample(-32'sd300000);
    send_sample(32'sd300000);
    set_quantile(17'd0, QONE);
    send_sample(-32'sd1000000);
    send_sample(32'sd123456);
    send_sample(-32'sd7);
    set_quantile(QONE, 17'd0);
    send_sample(32'sd42);
    send_sample(-32'sd42);
  endtask

  task automatic test_random_stream(input logic [Q_W-1:0] quantile,
                                    input logic [Q_W-1:0] threshold,
                                    input int unsigned count);
    longint centre;
    int unsigned k;
    set_quantile(quantile, threshold);
    centre = longint'($signed($urandom)) >>> $urandom_range(1, 8);
    for (k = 0; k < count; k++) begin
      send_sample(draw_sample(centre));
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        stall = draw_gap(SINK_SIDE);
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_estimates.size() == 0) begin
        $error("unexpected result: estimate %0d step_size %0d", res_if.estimate,
               res_if.step_size);
        mismatches++;
      end else begin
        oldest = expected_estimates.pop_front();
        results_checked++;
        if (res_if.estimate !== oldest.estimate) begin
          $error("estimate: expected %0d, got %0d", oldest.estimate, res_if.estimate);
          mismatches++;
        end
        if (res_if.step_size !== oldest.step_size) begin
          $error("step_size: expected %0d, got %0d", oldest.step_size, res_if.step_size);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out: no item moved for %0d cycles.", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    mismatches = 0;
    results_checked = 0;
    samples_sent = 0;
    settings_used = 0;
    calm_left[SEND_SIDE] = 0;
    calm_left[SINK_SIDE] = 0;
    tracked_estimate = 0;
    tracked_sum = 0;
    largest_sample = -QSCALE;
    smallest_sample = SMP_MAX;
    samples_seen = 0;
    below_hits = 0;
    above_hits = 0;
    target_q = TARGET_Q_RST;
    range_thr = RANGE_THR_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_sample_and_clipping();
    test_field_extremes();
    test_register_extremes();

    test_random_stream(TARGET_Q_RST, RANGE_THR_RST, 118);
    test_random_stream(QONE, 17'd0, 118);
    test_random_stream(17'd0, QONE, 118);
    test_random_stream(17'h1FFFF, 17'h1FFFF, 118);
    test_random_stream(17'd6554, QONE, 118);
    test_random_stream(17'd58982, RANGE_THR_RST, 118);
    test_random_stream(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)), 118);
    test_random_stream(17'h1FFFF, 17'd0, 118);

    drain_results();
    repeat (100) @(posedge clk_i);

    $display("Checked %0d results from %0d samples over %0d quantile settings.",
             results_checked, samples_sent, settings_used);
    if (mismatches == 0 && expected_estimates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
